FILE: sv/nsa_pkg.sv
// Shared types, constants and codes for the notch slot allocator.
// Used by the channel interfaces, the slot lanes, the merge stage and the top level.
package nsa_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAG_LANES = 4;
  localparam int FREQ_W = 19;
  localparam int AGE_W = 32;
  localparam int HOLD_W = 8;
  localparam int MAG_W = 16;
  localparam int TOL_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1125;
  localparam logic signed [MAG_W-1:0] THRESH_RESET = -16'sd10240;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd8;

  typedef enum logic [1:0] {
    REQ_BLOCK_START = 2'd0,
    REQ_EVENT       = 2'd1,
    REQ_RELEASE     = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPRESS  = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_HOLD      = 2'd3
  } cfg_index_t;

  // Command broadcast from the top level to every lane.
  typedef struct packed {
    logic                     blk_off;
    logic                     stamp;
    logic                     check;
    logic [FREQ_W-1:0]        freq;
    logic [TOL_W-1:0]         tol;
    logic [HOLD_W-1:0]        hold;
    logic [AGE_W-1:0]         age;
    logic signed [MAG_W-1:0]  thresh;
  } lane_cmd_t;

  // Status each lane reports to the merge stage and the outputs.
  typedef struct packed {
    logic active;
    logic enabled;
    logic match;
  } lane_stat_t;

endpackage

FILE: sv/nsa_req_if.sv
// Request channel carrying one request item with valid/ready handshake.
// Depends on nsa_pkg for field widths.
interface nsa_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [nsa_pkg::FREQ_W-1:0]       event_freq;
  logic signed [nsa_pkg::MAG_W-1:0] quiet_mag_0;
  logic signed [nsa_pkg::MAG_W-1:0] quiet_mag_1;
  logic signed [nsa_pkg::MAG_W-1:0] quiet_mag_2;
  logic signed [nsa_pkg::MAG_W-1:0] quiet_mag_3;

  modport source (output valid, req_type, event_freq, quiet_mag_0, quiet_mag_1,
                  quiet_mag_2, quiet_mag_3, input ready);
  modport sink (input valid, req_type, event_freq, quiet_mag_0, quiet_mag_1,
                quiet_mag_2, quiet_mag_3, output ready);
endinterface

FILE: sv/nsa_rsp_if.sv
// Result channel carrying one result item with valid/ready handshake.
// Depends on nsa_pkg for field widths.
interface nsa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 chosen_slot;
  logic                       slot_written;
  logic [3:0]                 active_mask;
  logic [3:0]                 enabled_mask;
  logic [nsa_pkg::FREQ_W-1:0] tuned_freq_0;
  logic [nsa_pkg::FREQ_W-1:0] tuned_freq_1;
  logic [nsa_pkg::FREQ_W-1:0] tuned_freq_2;
  logic [nsa_pkg::FREQ_W-1:0] tuned_freq_3;

  modport source (output valid, chosen_slot, slot_written, active_mask, enabled_mask,
                  tuned_freq_0, tuned_freq_1, tuned_freq_2, tuned_freq_3, input ready);
  modport sink (input valid, chosen_slot, slot_written, active_mask, enabled_mask,
                tuned_freq_0, tuned_freq_1, tuned_freq_2, tuned_freq_3, output ready);
endinterface

FILE: sv/nsa_slot_lane.sv
// One notch slot: holds its frequency, flags, quiet count and age, and
// reports a tolerance match. Depends on nsa_pkg.
module nsa_slot_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  nsa_pkg::lane_cmd_t               cmd,
  input  logic                             sel,
  input  logic signed [nsa_pkg::MAG_W-1:0] mag,
  input  logic                             mag_present,
  output nsa_pkg::lane_stat_t              stat,
  output logic [nsa_pkg::FREQ_W-1:0]       freq,
  output logic [nsa_pkg::AGE_W-1:0]        age
);

  logic                        active;
  logic                        enabled;
  logic [nsa_pkg::HOLD_W-1:0]  qcount;
  logic [nsa_pkg::FREQ_W-1:0]  diff;
  logic                        quiet;

  always_comb begin
    diff = (freq > cmd.freq) ? (freq - cmd.freq) : (cmd.freq - freq);
    stat.active = active;
    stat.enabled = enabled;
    stat.match = active && (diff < nsa_pkg::FREQ_W'(cmd.tol));
    quiet = mag_present && (mag < cmd.thresh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= '0;
      active <= 1'b0;
      enabled <= 1'b0;
      qcount <= '0;
      age <= '0;
    end else begin
      if (cmd.blk_off) begin
        enabled <= 1'b0;
      end
      if (cmd.stamp && sel) begin
        freq <= cmd.freq;
        active <= 1'b1;
        enabled <= 1'b1;
        age <= cmd.age;
        qcount <= cmd.hold;
      end
      if (cmd.check && active) begin
        if (quiet) begin
          if (qcount <= nsa_pkg::HOLD_W'(1)) begin
            qcount <= '0;
            active <= 1'b0;
            enabled <= 1'b0;
          end else begin
            qcount <= qcount - nsa_pkg::HOLD_W'(1);
          end
        end else begin
          qcount <= cmd.hold;
        end
      end
    end
  end

endmodule

FILE: sv/nsa_merge.sv
// Merges lane status into one slot choice: lowest matching active slot,
// else lowest free slot, else the oldest slot. Depends on nsa_pkg.
module nsa_merge (
  input  nsa_pkg::lane_stat_t        stat [nsa_pkg::NUM_SLOTS],
  input  logic [nsa_pkg::AGE_W-1:0]  age [nsa_pkg::NUM_SLOTS],
  output logic [nsa_pkg::SLOT_W-1:0] sel
);

  logic [nsa_pkg::SLOT_W-1:0] match_idx;
  logic [nsa_pkg::SLOT_W-1:0] free_idx;
  logic [nsa_pkg::SLOT_W-1:0] old_idx;
  logic [nsa_pkg::AGE_W-1:0]  old_age;
  logic                       any_match;
  logic                       any_free;

  always_comb begin
    match_idx = '0;
    free_idx = '0;
    any_match = 1'b0;
    any_free = 1'b0;
    old_idx = '0;
    old_age = age[0];
    for (int i = nsa_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (stat[i].match) begin
        match_idx = nsa_pkg::SLOT_W'(i);
        any_match = 1'b1;
      end
      if (!stat[i].active) begin
        free_idx = nsa_pkg::SLOT_W'(i);
        any_free = 1'b1;
      end
    end
    for (int i = 1; i < nsa_pkg::NUM_SLOTS; i++) begin
      if (age[i] < old_age) begin
        old_age = age[i];
        old_idx = nsa_pkg::SLOT_W'(i);
      end
    end
    if (any_match) begin
      sel = match_idx;
    end else if (any_free) begin
      sel = free_idx;
    end else begin
      sel = old_idx;
    end
  end

endmodule

FILE: sv/notch_slot_allocator_core.sv
// Notch slot allocator top level: configuration registers, block counter,
// slot lanes, merge stage and result register.
// Depends on nsa_pkg, nsa_req_if, nsa_rsp_if, nsa_slot_lane and nsa_merge.
//
// Usage: requests arrive on the req channel and each produces exactly one
// result item on the rsp channel. A block start advances the block counter
// and, with suppression off, disables all notches. With suppression on, a
// detection event picks and retunes a slot; a release check counts quiet
// slots down and frees them. Configuration is written through cfg_we,
// cfg_index and cfg_data by the user only while the block is idle; the
// block does not enforce this. The result is registered and valid the cycle
// after acceptance. Throughput: one item per cycle while the receiver keeps
// up; all slot lanes compare in parallel and the merge stage picks the slot
// within the same cycle. A request is taken while the result register is
// empty or being emptied in the same cycle, so a stalled receiver holds the
// current result stable and blocks new requests until it is taken.
// Reset clears all slots, the block counter and the result register, and
// loads the configuration registers with their defaults.
module notch_slot_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [nsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nsa_pkg::CFG_W-1:0]       cfg_data,
  nsa_req_if.sink                         req,
  nsa_rsp_if.source                       rsp
);

  logic                             suppress;
  logic [nsa_pkg::TOL_W-1:0]        tol;
  logic signed [nsa_pkg::MAG_W-1:0] thresh;
  logic [nsa_pkg::HOLD_W-1:0]       hold;
  logic [nsa_pkg::AGE_W-1:0]        block_count;
  logic                             out_valid;
  logic [1:0]                       chosen;
  logic                             written;
  logic                             accept;
  nsa_pkg::lane_cmd_t               cmd;
  logic [nsa_pkg::SLOT_W-1:0]       sel;
  nsa_pkg::lane_stat_t              stat [nsa_pkg::NUM_SLOTS];
  logic [nsa_pkg::AGE_W-1:0]        age [nsa_pkg::NUM_SLOTS];
  logic [nsa_pkg::FREQ_W-1:0]       freq [nsa_pkg::NUM_SLOTS];
  logic signed [nsa_pkg::MAG_W-1:0] mags [nsa_pkg::MAG_LANES];
  logic [nsa_pkg::FREQ_W-1:0]       out_freq [4];
  logic [3:0]                       amask;
  logic [3:0]                       emask;

  assign req.ready = !rst && (!out_valid || rsp.ready);
  assign accept = req.valid && req.ready;

  assign mags[0] = req.quiet_mag_0;
  assign mags[1] = req.quiet_mag_1;
  assign mags[2] = req.quiet_mag_2;
  assign mags[3] = req.quiet_mag_3;

  always_comb begin
    cmd.blk_off = 1'b0;
    cmd.stamp = 1'b0;
    cmd.check = 1'b0;
    cmd.freq = req.event_freq;
    cmd.tol = tol;
    cmd.hold = hold;
    cmd.age = block_count;
    cmd.thresh = thresh;
    if (accept) begin
      case (req.req_type)
        nsa_pkg::REQ_BLOCK_START: cmd.blk_off = !suppress;
        nsa_pkg::REQ_EVENT:       cmd.stamp = suppress;
        nsa_pkg::REQ_RELEASE:     cmd.check = suppress;
        default:                  cmd.blk_off = 1'b0;
      endcase
    end
  end

  for (genvar i = 0; i < nsa_pkg::NUM_SLOTS; i++) begin : g_lane
    logic signed [nsa_pkg::MAG_W-1:0] lane_mag;
    logic                             lane_has_mag;
    if (i < nsa_pkg::MAG_LANES) begin : g_mag
      assign lane_mag = mags[i];
      assign lane_has_mag = 1'b1;
    end else begin : g_nomag
      assign lane_mag = '0;
      assign lane_has_mag = 1'b0;
    end
    nsa_slot_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .sel         (sel == nsa_pkg::SLOT_W'(i)),
      .mag         (lane_mag),
      .mag_present (lane_has_mag),
      .stat        (stat[i]),
      .freq        (freq[i]),
      .age         (age[i])
    );
  end

  nsa_merge u_merge (
    .stat (stat),
    .age  (age),
    .sel  (sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      suppress <= 1'b0;
      tol <= nsa_pkg::TOL_RESET;
      thresh <= nsa_pkg::THRESH_RESET;
      hold <= nsa_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nsa_pkg::CFG_SUPPRESS:  suppress <= cfg_data[0];
        nsa_pkg::CFG_TOLERANCE: tol <= cfg_data[nsa_pkg::TOL_W-1:0];
        nsa_pkg::CFG_THRESHOLD: thresh <= cfg_data[nsa_pkg::MAG_W-1:0];
        nsa_pkg::CFG_HOLD:      hold <= cfg_data[nsa_pkg::HOLD_W-1:0];
        default:                hold <= hold;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      out_valid <= 1'b0;
      chosen <= '0;
      written <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        chosen <= cmd.stamp ? 2'(sel) : 2'd0;
        written <= cmd.stamp;
        if (req.req_type == nsa_pkg::REQ_BLOCK_START && block_count != '1) begin
          block_count <= block_count + nsa_pkg::AGE_W'(1);
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The slot table only changes when a new item is accepted, which also
  // reloads the result register, so the snapshot is read from the lanes.
  always_comb begin
    amask = '0;
    emask = '0;
    for (int i = 0; i < 4; i++) begin
      out_freq[i] = '0;
      if (i < nsa_pkg::NUM_SLOTS) begin
        amask[i] = stat[i].active;
        emask[i] = stat[i].enabled;
        out_freq[i] = freq[i];
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.chosen_slot = chosen;
  assign rsp.slot_written = written;
  assign rsp.active_mask = amask;
  assign rsp.enabled_mask = emask;
  assign rsp.tuned_freq_0 = out_freq[0];
  assign rsp.tuned_freq_1 = out_freq[1];
  assign rsp.tuned_freq_2 = out_freq[2];
  assign rsp.tuned_freq_3 = out_freq[3];

endmodule
